/* src/gibbs_sampler_binary_ring_macros.svh */
// Assertion helpers used by the checker file.
`ifndef GIBBS_SAMPLER_BINARY_RING_MACROS_SVH
`define GIBBS_SAMPLER_BINARY_RING_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define GSBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define GSBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gsbr_pkg.sv */
package gsbr_pkg;

    localparam int DEF_WEIGHT_BITS = 8;
    localparam int DEF_RAND_BITS   = 16;
    localparam int DEF_COUNT_BITS  = 24;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int NODE_BITS     = 2;
    localparam int ASSIGN_BITS   = 4;
    localparam int EVID_BITS     = 3;

    localparam logic [CFG_DATA_BITS-1:0] RST_FACTOR_AB = 32'h0A01051E;
    localparam logic [CFG_DATA_BITS-1:0] RST_FACTOR_BC = 32'h64010164;
    localparam logic [CFG_DATA_BITS-1:0] RST_FACTOR_CD = 32'h01646401;
    localparam logic [CFG_DATA_BITS-1:0] RST_FACTOR_DA = 32'h64010164;
    localparam logic [EVID_BITS-1:0]     RST_EVIDENCE  = 3'd1;
    localparam logic [ASSIGN_BITS-1:0]   RST_INIT      = 4'd2;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FACTOR_AB = 3'd0,
        REG_FACTOR_BC = 3'd1,
        REG_FACTOR_CD = 3'd2,
        REG_FACTOR_DA = 3'd3,
        REG_EVIDENCE  = 3'd4,
        REG_INIT      = 3'd5
    } cfg_index_t;

    typedef enum logic [NODE_BITS-1:0] {
        NODE_A = 2'd0,
        NODE_B = 2'd1,
        NODE_C = 2'd2,
        NODE_D = 2'd3
    } node_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // request accepted: latch input, form weights
        logic commit;   // decide, update state, load output register
    } gsbr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // output register empty or being taken this cycle
    } gsbr_status_t;

endpackage

/* src/gibbs_sampler_binary_ring.sv */
// Gibbs sampler over four binary nodes A-B-C-D in a ring of pairwise factors.
// Input stream: s_tdata carries a Q0.RAND_BITS uniform fraction, s_tuser the
// restart flag (reload the initial assignment, clear counts, restart at A).
// Each request visits the next node round-robin, redraws it from its two ring
// neighbors unless it is the evidence node, and returns one result on the
// output stream: visited node, assignment and the saturating A=0 / A=1 /
// sampled-step counts in m_tdata, the was-sampled flag in m_tuser.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the four factor tables, the
// evidence node and the initial assignment; write only while idle.
// Flow: the weight multiply runs in the accept cycle, then the calc state
// does the product compare and state update and loads the result register
// once the output register is free; no new request is taken until then.
// Reset: factors, evidence and start values take their defaults, the counts
// clear, the assignment loads the default start values, no result is pending.
// Output stall: a waiting result holds in the output register; the block does
// not finish the next request until that register frees.
module gibbs_sampler_binary_ring
    import gsbr_pkg::*;
#(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int RAND_BITS   = DEF_RAND_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // rand_fraction
    input  logic [((RAND_BITS+7)/8)*8-1:0] s_tdata,
    // restart
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // visited_node, assignment, a_zero_count, a_one_count, sampled_steps
    output logic [((NODE_BITS+ASSIGN_BITS+3*COUNT_BITS+7)/8)*8-1:0] m_tdata,
    // was_sampled
    output logic                     m_tuser
);

    localparam int OUT_BITS   = NODE_BITS + ASSIGN_BITS + 3 * COUNT_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    gsbr_cmd_t    cmd;
    gsbr_status_t status;

    logic [NODE_BITS-1:0]   visited_node;
    logic [ASSIGN_BITS-1:0] assignment;
    logic [COUNT_BITS-1:0]  a_zero_count, a_one_count, sampled_steps;
    logic [OUT_BITS-1:0]    out_packed;

    gsbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gsbr_dp #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .RAND_BITS   (RAND_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .rand_fraction (s_tdata[RAND_BITS-1:0]),
        .restart       (s_tuser),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .visited_node  (visited_node),
        .was_sampled   (m_tuser),
        .assignment    (assignment),
        .a_zero_count  (a_zero_count),
        .a_one_count   (a_one_count),
        .sampled_steps (sampled_steps)
    );

    assign out_packed = {sampled_steps, a_one_count, a_zero_count, assignment, visited_node};
    assign m_tdata    = OUT_TDATA_W'(out_packed);

endmodule

/* src/gsbr_ctrl.sv */
module gsbr_ctrl
    import gsbr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  gsbr_status_t status,
    output gsbr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* src/gsbr_dp.sv */
module gsbr_dp
    import gsbr_pkg::*;
#(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int RAND_BITS   = DEF_RAND_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic [RAND_BITS-1:0]     rand_fraction,
    input  logic                     restart,
    input  gsbr_cmd_t                cmd,
    output gsbr_status_t             status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [NODE_BITS-1:0]     visited_node,
    output logic                     was_sampled,
    output logic [ASSIGN_BITS-1:0]   assignment,
    output logic [COUNT_BITS-1:0]    a_zero_count,
    output logic [COUNT_BITS-1:0]    a_one_count,
    output logic [COUNT_BITS-1:0]    sampled_steps
);

    localparam int W_BITS    = 2 * WEIGHT_BITS;
    localparam int PROD_BITS = RAND_BITS + W_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [WEIGHT_BITS-1:0] weight_of(
        input logic [CFG_DATA_BITS-1:0] f,
        input logic [1:0]               e
    );
        logic [4*WEIGHT_BITS+CFG_DATA_BITS-1:0] ext;
        ext = {{(4*WEIGHT_BITS){1'b0}}, f};
        return ext[int'(e)*WEIGHT_BITS +: WEIGHT_BITS];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

    // configuration
    logic [CFG_DATA_BITS-1:0] factor_ab_reg, factor_bc_reg, factor_cd_reg, factor_da_reg;
    logic [EVID_BITS-1:0]     evidence_reg;
    logic [ASSIGN_BITS-1:0]   init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_ab_reg <= RST_FACTOR_AB;
            factor_bc_reg <= RST_FACTOR_BC;
            factor_cd_reg <= RST_FACTOR_CD;
            factor_da_reg <= RST_FACTOR_DA;
            evidence_reg  <= RST_EVIDENCE;
            init_reg      <= RST_INIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FACTOR_AB: factor_ab_reg <= cfg_wdata;
                REG_FACTOR_BC: factor_bc_reg <= cfg_wdata;
                REG_FACTOR_CD: factor_cd_reg <= cfg_wdata;
                REG_FACTOR_DA: factor_da_reg <= cfg_wdata;
                REG_EVIDENCE:  evidence_reg  <= cfg_wdata[EVID_BITS-1:0];
                REG_INIT:      init_reg      <= cfg_wdata[ASSIGN_BITS-1:0];
                default:       ; // drop writes beyond the register list
            endcase
        end
    end

    function automatic logic [CFG_DATA_BITS-1:0] factor_sel(
        input logic [NODE_BITS-1:0]     edge_idx,
        input logic [CFG_DATA_BITS-1:0] f_ab,
        input logic [CFG_DATA_BITS-1:0] f_bc,
        input logic [CFG_DATA_BITS-1:0] f_cd,
        input logic [CFG_DATA_BITS-1:0] f_da
    );
        logic [CFG_DATA_BITS-1:0] f;
        unique case (edge_idx)
            NODE_A:  f = f_ab;
            NODE_B:  f = f_bc;
            NODE_C:  f = f_cd;
            default: f = f_da;
        endcase
        return f;
    endfunction

    // sampler state
    logic [ASSIGN_BITS-1:0] vals_reg, vals_next;
    logic [NODE_BITS-1:0]   next_node_reg;
    logic [COUNT_BITS-1:0]  zero_reg, zero_next;
    logic [COUNT_BITS-1:0]  one_reg, one_next;
    logic [COUNT_BITS-1:0]  steps_reg, steps_next;

    // step registers between the load and commit cycles
    logic [NODE_BITS-1:0]   node_reg;
    logic                   sampled_reg;
    logic [RAND_BITS-1:0]   rand_reg;
    logic [W_BITS-1:0]      w0_reg, w1_reg;

    // load cycle: apply restart, then form the two weights
    logic [ASSIGN_BITS-1:0] vals_eff;
    logic [NODE_BITS-1:0]   node_eff, prev_node, nxt_node;
    logic                   pv, nv;
    logic [CFG_DATA_BITS-1:0] left_f, right_f;
    logic [W_BITS-1:0]      w0_calc, w1_calc;

    always_comb
    begin
        vals_eff  = restart ? init_reg : vals_reg;
        node_eff  = restart ? NODE_A : next_node_reg;
        prev_node = node_eff - 1'b1;
        nxt_node  = node_eff + 1'b1;
        pv        = vals_eff[prev_node];
        nv        = vals_eff[nxt_node];
        left_f    = factor_sel(prev_node, factor_ab_reg, factor_bc_reg,
                               factor_cd_reg, factor_da_reg);
        right_f   = factor_sel(node_eff, factor_ab_reg, factor_bc_reg,
                               factor_cd_reg, factor_da_reg);
        w0_calc   = W_BITS'(weight_of(left_f, {pv, 1'b0}))
                  * W_BITS'(weight_of(right_f, {1'b0, nv}));
        w1_calc   = W_BITS'(weight_of(left_f, {pv, 1'b1}))
                  * W_BITS'(weight_of(right_f, {1'b1, nv}));
    end

    // commit cycle: compare rand*w1 against w0*(1 - rand) (a tie gives 0, two zero weights give 1)
    logic [RAND_BITS:0]    rand_comp;
    logic [PROD_BITS-1:0]  lhs, rhs;
    logic                  new_bit;
    logic [ASSIGN_BITS-1:0] vals_upd;

    always_comb
    begin
        rand_comp = {1'b1, {RAND_BITS{1'b0}}} - {1'b0, rand_reg};
        lhs       = PROD_BITS'(rand_reg) * PROD_BITS'(w1_reg);
        rhs       = PROD_BITS'(rand_comp) * PROD_BITS'(w0_reg);
        if (w0_reg == '0 && w1_reg == '0)
            new_bit = 1'b1;
        else
            new_bit = (lhs <= rhs) ? 1'b0 : 1'b1;
        vals_upd           = vals_reg;
        vals_upd[node_reg] = new_bit;

        vals_next  = vals_reg;
        zero_next  = zero_reg;
        one_next   = one_reg;
        steps_next = steps_reg;
        if (sampled_reg)
        begin
            vals_next  = vals_upd;
            steps_next = sat_inc(steps_reg);
            if (vals_upd[NODE_A])
                one_next = sat_inc(one_reg);
            else
                zero_next = sat_inc(zero_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vals_reg      <= RST_INIT;
            next_node_reg <= NODE_A;
            zero_reg      <= '0;
            one_reg       <= '0;
            steps_reg     <= '0;
        end
        else if (cmd.load)
        begin
            vals_reg      <= vals_eff;
            next_node_reg <= node_eff + 1'b1;
            if (restart)
            begin
                zero_reg  <= '0;
                one_reg   <= '0;
                steps_reg <= '0;
            end
        end
        else if (cmd.commit)
        begin
            vals_reg  <= vals_next;
            zero_reg  <= zero_next;
            one_reg   <= one_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            node_reg    <= node_eff;
            sampled_reg <= ({1'b0, node_eff} != evidence_reg);
            rand_reg    <= rand_fraction;
            w0_reg      <= w0_calc;
            w1_reg      <= w1_calc;
        end
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            visited_node  <= node_reg;
            was_sampled   <= sampled_reg;
            assignment    <= vals_next;
            a_zero_count  <= zero_next;
            a_one_count   <= one_next;
            sampled_steps <= steps_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

/* src/gsbr_checker.sv */
`include "gibbs_sampler_binary_ring_macros.svh"

module gsbr_checker
    import gsbr_pkg::*;
#(
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    parameter int OUT_TDATA_W = ((NODE_BITS + ASSIGN_BITS + 3 * DEF_COUNT_BITS + 7) / 8) * 8
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    localparam int ZERO_LSB  = NODE_BITS + ASSIGN_BITS;
    localparam int ONE_LSB   = ZERO_LSB + COUNT_BITS;
    localparam int STEPS_LSB = ONE_LSB + COUNT_BITS;

    logic [COUNT_BITS-1:0] zero_cnt, one_cnt, steps_cnt;
    logic [COUNT_BITS:0]   tally_sum;
    logic                  steps_below_max;

    assign zero_cnt        = m_tdata[ZERO_LSB  +: COUNT_BITS];
    assign one_cnt         = m_tdata[ONE_LSB   +: COUNT_BITS];
    assign steps_cnt       = m_tdata[STEPS_LSB +: COUNT_BITS];
    assign tally_sum       = {1'b0, zero_cnt} + {1'b0, one_cnt};
    assign steps_below_max = (steps_cnt != {COUNT_BITS{1'b1}});

    `GSBR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `GSBR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready,
        !s_tready, "request accepted while previous one still in work")

    `GSBR_ASSERT_NOW(a_tally_sum, clk, rst_n, m_tvalid && steps_below_max,
        tally_sum == {1'b0, steps_cnt}, "A tallies do not add up to sampled steps")

    `GSBR_ASSERT_NOW(a_result_after_work, clk, rst_n, $rose(m_tvalid),
        !$past(s_tready), "result appeared without a request in work")

endmodule

bind gibbs_sampler_binary_ring gsbr_checker #(
    .COUNT_BITS  (COUNT_BITS),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_gsbr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
